/* sv/utf8bd_pkg.sv */
// ---------------------------------------------------------------------------
// utf8bd_pkg
// Shared types and constants for the UTF-8b stream decoder.
// ---------------------------------------------------------------------------
package utf8bd_pkg;

   localparam int unsigned CpWidth   = 21;
   localparam int unsigned MaxOut    = 4;
   localparam int unsigned CntWidth  = 3;

   // Escape base for stray bytes (0xDC00 | byte)
   localparam logic [CpWidth-1:0] EscBase    = 21'h00DC00;

   // Lead byte bounds
   localparam logic [7:0] AsciiLimit = 8'h80;
   localparam logic [7:0] LeadMin    = 8'hC2;
   localparam logic [7:0] LeadMax    = 8'hF4;
   localparam logic [7:0] Lead3Min   = 8'hE0;
   localparam logic [7:0] Lead4Min   = 8'hF0;

   // Continuation byte tag in the top two bits
   localparam logic [1:0] ContTag    = 2'b10;

   // Code point range limits
   localparam logic [CpWidth-1:0] Min3Byte  = 21'h000800;
   localparam logic [CpWidth-1:0] SurrLow   = 21'h00D800;
   localparam logic [CpWidth-1:0] SurrEnd   = 21'h00E000;
   localparam logic [CpWidth-1:0] Min4Byte  = 21'h010000;
   localparam logic [CpWidth-1:0] CpLimit   = 21'h110000;

   // Sequence lengths
   localparam logic [2:0] Len2 = 3'd2;
   localparam logic [2:0] Len3 = 3'd3;
   localparam logic [2:0] Len4 = 3'd4;

   // One result item
   typedef struct packed {
      logic [CpWidth-1:0] cp;
      logic               esc;
   } result_type;

   // All results caused by one request
   typedef struct packed {
      logic [CntWidth-1:0]       count;
      result_type [MaxOut-1:0]   ent;
   } burst_type;

   // Escape entry for a raw byte
   function automatic result_type escape_of(input logic [7:0] b);
      result_type r;
      r.cp  = EscBase | {13'd0, b};
      r.esc = 1'b1;
      return r;
   endfunction

endpackage

/* sv/utf8b_stream_decoder_core.sv */
// ---------------------------------------------------------------------------
// utf8b_stream_decoder_core
// Byte-serial UTF-8b decoder: valid code points pass through, bytes that
// cannot be decoded come out as 0xDC00|byte escapes.
// ---------------------------------------------------------------------------
//  channel   direction  ports                                   meaning
//  req_      in         in_byte, end_of_input                   one raw byte
//  rsp_      out        code_point, is_escape, last_of_run      one result
//
//  A request is held in the input register, is decoded in one pass
//  and its 0..4 results land in the result register; one result leaves per
//  cycle while rsp_ready is high.
//  Requests flow one per cycle while each causes at most one result and rsp_ready stays high.
//  Reset clears the pending sequence and both registers' valid flags.
//  A stalled rsp_ready holds the result register, then the input register.
// ---------------------------------------------------------------------------
module utf8b_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_escape,
   output logic        rsp_last_of_run
);

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eof_ff;
   logic        free;
   logic        fire;
   utf8bd_pkg::burst_type burst;

   // Decode moves when the result register can take the next burst
   assign fire      = in_vld_ff && free;
   assign req_ready = !in_vld_ff || fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eof_ff  <= req_end_of_input;
      end
   end

   utf8bd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .in_byte      (in_byte_ff),
      .end_of_input (in_eof_ff),
      .burst        (burst)
   );

   utf8bd_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (fire),
      .burst           (burst),
      .free            (free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_escape   (rsp_is_escape),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* sv/utf8bd_decode.sv */
// ---------------------------------------------------------------------------
// utf8bd_decode
// Decodes one byte against the pending sequence state and produces the
// full list of results for that request; holds the pending sequence.
// ---------------------------------------------------------------------------
module utf8bd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_input,
   output utf8bd_pkg::burst_type burst
);

   // Pending sequence state
   logic [1:0] pend_cnt_ff, pend_cnt_in;
   logic [7:0] pend_lead_ff, pend_lead_in;
   logic [7:0] pend_c0_ff, pend_c0_in;
   logic [7:0] pend_c1_ff, pend_c1_in;

   logic [utf8bd_pkg::CntWidth-1:0] n;
   logic [7:0]  old_bytes [3];
   logic [7:0]  new_bytes [3];
   logic        is_cont;
   logic [2:0]  need;
   logic [2:0]  have;
   logic        do_flush;
   logic        do_fresh;
   logic        single_vld;
   logic [utf8bd_pkg::CpWidth-1:0] val2, val3, val4, val;
   logic        ok;

   assign is_cont = (in_byte[7:6] == utf8bd_pkg::ContTag);
   assign need    = (pend_lead_ff < utf8bd_pkg::Lead3Min) ? utf8bd_pkg::Len2 :
                    (pend_lead_ff < utf8bd_pkg::Lead4Min) ? utf8bd_pkg::Len3 :
                                                            utf8bd_pkg::Len4;
   assign have    = {1'b0, pend_cnt_ff} + 3'd1;

   // Candidate code points for each sequence length
   assign val2 = {10'd0, pend_lead_ff[4:0], in_byte[5:0]};
   assign val3 = {5'd0, pend_lead_ff[3:0], pend_c0_ff[5:0], in_byte[5:0]};
   assign val4 = {pend_lead_ff[2:0], pend_c0_ff[5:0], pend_c1_ff[5:0], in_byte[5:0]};

   always_comb begin
      case (need)
         utf8bd_pkg::Len2: begin
            val = val2;
            ok  = 1'b1;
         end
         utf8bd_pkg::Len3: begin
            val = val3;
            ok  = (val3 >= utf8bd_pkg::Min3Byte) &&
                  ((val3 < utf8bd_pkg::SurrLow) || (val3 >= utf8bd_pkg::SurrEnd));
         end
         default: begin
            val = val4;
            ok  = (val4 >= utf8bd_pkg::Min4Byte) && (val4 < utf8bd_pkg::CpLimit);
         end
      endcase
   end

   // Result list and next pending state
   always_comb begin
      burst       = '0;
      n           = '0;
      pend_cnt_in  = pend_cnt_ff;
      pend_lead_in = pend_lead_ff;
      pend_c0_in   = pend_c0_ff;
      pend_c1_in   = pend_c1_ff;
      do_flush    = 1'b0;
      do_fresh    = 1'b0;
      single_vld  = 1'b0;
      old_bytes[0] = pend_lead_ff;
      old_bytes[1] = pend_c0_ff;
      old_bytes[2] = pend_c1_ff;

      if (pend_cnt_ff != 2'd0 && !is_cont) begin
         do_flush = 1'b1;
         do_fresh = 1'b1;
      end else if (pend_cnt_ff != 2'd0) begin
         if (have < need) begin
            // still collecting continuation bytes
            if (pend_cnt_ff == 2'd1) begin
               pend_c0_in = in_byte;
            end else begin
               pend_c1_in = in_byte;
            end
            pend_cnt_in = have[1:0];
         end else if (ok) begin
            single_vld  = 1'b1;
            pend_cnt_in = 2'd0;
         end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
         end
      end else begin
         do_fresh = 1'b1;
      end

      // escape the old pending bytes in order
      if (do_flush) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < pend_cnt_ff) begin
               burst.ent[n[1:0]] = utf8bd_pkg::escape_of(old_bytes[i]);
               n = n + 3'd1;
            end
         end
         pend_cnt_in = 2'd0;
      end

      // current byte as a new lead
      if (do_fresh) begin
         if (in_byte < utf8bd_pkg::AsciiLimit) begin
            burst.ent[n[1:0]].cp  = {13'd0, in_byte};
            burst.ent[n[1:0]].esc = 1'b0;
            n = n + 3'd1;
         end else if (in_byte < utf8bd_pkg::LeadMin || in_byte > utf8bd_pkg::LeadMax) begin
            burst.ent[n[1:0]] = utf8bd_pkg::escape_of(in_byte);
            n = n + 3'd1;
         end else begin
            pend_lead_in = in_byte;
            pend_cnt_in  = 2'd1;
         end
      end

      // completed sequence
      if (single_vld) begin
         burst.ent[n[1:0]].cp  = val;
         burst.ent[n[1:0]].esc = 1'b0;
         n = n + 3'd1;
      end

      // end of input: flush whatever is still pending
      new_bytes[0] = pend_lead_in;
      new_bytes[1] = pend_c0_in;
      new_bytes[2] = pend_c1_in;
      if (end_of_input) begin
         for (int j = 0; j < 3; j++) begin
            if (2'(j) < pend_cnt_in) begin
               burst.ent[n[1:0]] = utf8bd_pkg::escape_of(new_bytes[j]);
               n = n + 3'd1;
            end
         end
         pend_cnt_in = 2'd0;
      end

      burst.count = n;
   end

   // Pending count
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= 2'd0;
      end else if (fire) begin
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   // Pending bytes, no reset needed
   always_ff @(posedge clock) begin
      if (fire) begin
         pend_lead_ff <= pend_lead_in;
         pend_c0_ff   <= pend_c0_in;
         pend_c1_ff   <= pend_c1_in;
      end
   end

endmodule

/* sv/utf8bd_burst.sv */
// ---------------------------------------------------------------------------
// utf8bd_burst
// Result register: holds the results of one request and hands them out
// one per cycle on the result channel while rsp_ready is high.
// ---------------------------------------------------------------------------
module utf8bd_burst (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  utf8bd_pkg::burst_type burst,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [20:0]           rsp_code_point,
   output logic                  rsp_is_escape,
   output logic                  rsp_last_of_run
);

   logic                                vld_ff, vld_in;
   logic [utf8bd_pkg::CntWidth-1:0]     cnt_ff, cnt_in;
   logic [1:0]                          idx_ff, idx_in;
   utf8bd_pkg::result_type [utf8bd_pkg::MaxOut-1:0] ent_ff;
   logic                                last;
   logic                                take;

   assign last = ({1'b0, idx_ff} + 3'd1) == cnt_ff;
   assign take = vld_ff && rsp_ready;
   assign free = !vld_ff || (take && last);

   assign rsp_valid       = vld_ff;
   assign rsp_code_point  = ent_ff[idx_ff].cp;
   assign rsp_is_escape   = ent_ff[idx_ff].esc;
   assign rsp_last_of_run = last;

   // Next-state for the output sequencer
   always_comb begin
      vld_in = vld_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (take) begin
         if (last) begin
            vld_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (load && burst.count != '0) begin
         vld_in = 1'b1;
         cnt_in = burst.count;
         idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         ent_ff <= burst.ent;
      end
   end

endmodule
